// ===== sv/bcalu_pkg.sv =====
// Shared types and constants for the BCD-capable 8-bit ALU.
// No dependencies; imported by every module of the block.
package bcalu_pkg;

   // operation codes; codes 18 to 31 are unused and pass acc and flags through
   typedef enum logic [4:0] {
      OP_ORA    = 5'd0,
      OP_AND    = 5'd1,
      OP_EOR    = 5'd2,
      OP_ADC    = 5'd3,
      OP_SBC    = 5'd4,
      OP_CMP    = 5'd5,
      OP_BIT    = 5'd6,
      OP_BITIMM = 5'd7,
      OP_ASL    = 5'd8,
      OP_LSR    = 5'd9,
      OP_ROL    = 5'd10,
      OP_ROR    = 5'd11,
      OP_INC    = 5'd12,
      OP_DEC    = 5'd13,
      OP_TSB    = 5'd14,
      OP_TRB    = 5'd15,
      OP_RMB    = 5'd16,
      OP_SMB    = 5'd17
   } op_type;

   // decimal adjust constants
   localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
   localparam logic [5:0] BCD_NIB_ADJ   = 6'h06;
   localparam logic [7:0] BCD_HI_ADJ    = 8'h60;
   localparam logic [7:0] BCD_LO_ADJ    = 8'h06;

   // one request as held in the input register
   typedef struct packed {
      logic [4:0] op;
      logic [7:0] acc;
      logic [7:0] operand;
      logic [2:0] bit_index;
      logic       carry_in;
      logic       decimal_in;
      logic       negative_in;
      logic       zero_in;
      logic       overflow_in;
   } req_type;

   // one result as held in the output register
   typedef struct packed {
      logic [7:0] result;
      logic       negative;
      logic       zero;
      logic       overflow;
      logic       carry;
      logic       extra_cycle;
   } rsp_type;

   // decimal unit outputs
   typedef struct packed {
      logic [7:0] adc_result;
      logic       adc_overflow;
      logic       adc_carry;
      logic [7:0] sbc_result;
   } bcd_type;

endpackage

// ===== sv/bcalu_bcd.sv =====
// Decimal (packed BCD) add and subtract correction for adc and sbc.
// Depends on bcalu_pkg for the adjust constants and the bcd_type struct.
module bcalu_bcd
   import bcalu_pkg::*;
(
   input  logic [7:0] acc,
   input  logic [7:0] operand,
   input  logic       carry_in,
   output bcd_type    bcd
);

   logic [5:0] add_lo;
   logic [5:0] add_lo_adj;
   logic       add_lo_carry;
   logic [5:0] add_hi;
   logic [5:0] add_hi_adj;
   logic [8:0] sub_bin;
   logic [4:0] sub_lo;
   logic [7:0] sub_res;
   logic       borrow_in;

   always_comb begin
      // decimal add: low digit, then high digit with the low carry
      add_lo       = {2'b00, acc[3:0]} + {2'b00, operand[3:0]} + {5'b0, carry_in};
      add_lo_adj   = (add_lo > {2'b00, BCD_DIGIT_MAX}) ? add_lo + BCD_NIB_ADJ : add_lo;
      add_lo_carry = (add_lo_adj[5:4] != 2'b00);
      add_hi       = {2'b00, acc[7:4]} + {2'b00, operand[7:4]} + {5'b0, add_lo_carry};
      add_hi_adj   = (add_hi > {2'b00, BCD_DIGIT_MAX}) ? add_hi + BCD_NIB_ADJ : add_hi;
      bcd.adc_result   = {add_hi_adj[3:0], add_lo_adj[3:0]};
      // overflow from the high sum before its correction
      bcd.adc_overflow = ~(acc[7] ^ operand[7]) & (acc[7] ^ add_hi[3]);
      bcd.adc_carry    = (add_hi_adj[5:4] != 2'b00);

      // decimal subtract: correct the binary difference by digit borrows
      borrow_in = ~carry_in;
      sub_bin   = {1'b0, acc} - {1'b0, operand} - {8'b0, borrow_in};
      sub_lo    = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'b0, borrow_in};
      sub_res   = sub_bin[7:0];
      if (sub_bin[8]) begin
         sub_res = sub_res - BCD_HI_ADJ;
      end
      if (sub_lo[4]) begin
         sub_res = sub_res - BCD_LO_ADJ;
      end
      bcd.sbc_result = sub_res;
   end

endmodule

// ===== sv/bcalu_core.sv =====
// Single-pass ALU datapath: logic, arithmetic, shifts, bit ops and flags.
// Depends on bcalu_pkg and on bcalu_bcd for the decimal mode.
module bcalu_core
   import bcalu_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   bcd_type    bcd;
   logic [8:0] add_sum;
   logic [8:0] sub_sum;
   logic [8:0] cmp_diff;
   logic [7:0] bit_mask;
   logic [7:0] and_val;
   logic [7:0] r;
   logic       n;
   logic       z;
   logic       v;
   logic       c;
   logic       x;
   logic       setnz;

   bcalu_bcd u_bcd (
      .acc      (req.acc),
      .operand  (req.operand),
      .carry_in (req.carry_in),
      .bcd      (bcd)
   );

   // shared adders
   always_comb begin
      add_sum  = {1'b0, req.acc} + {1'b0, req.operand} + {8'b0, req.carry_in};
      sub_sum  = {1'b0, req.acc} - {1'b0, req.operand} - {8'b0, ~req.carry_in};
      cmp_diff = {1'b0, req.acc} - {1'b0, req.operand};
      bit_mask = 8'b1 << req.bit_index;
      and_val  = req.acc & req.operand;
   end

   // operation select and flag update
   always_comb begin
      r     = req.acc;
      n     = req.negative_in;
      z     = req.zero_in;
      v     = req.overflow_in;
      c     = req.carry_in;
      x     = 1'b0;
      setnz = 1'b0;
      unique case (op_type'(req.op))
         OP_ORA: begin
            r = req.acc | req.operand;
            setnz = 1'b1;
         end
         OP_AND: begin
            r = and_val;
            setnz = 1'b1;
         end
         OP_EOR: begin
            r = req.acc ^ req.operand;
            setnz = 1'b1;
         end
         OP_ADC: begin
            setnz = 1'b1;
            if (req.decimal_in) begin
               r = bcd.adc_result;
               v = bcd.adc_overflow;
               c = bcd.adc_carry;
               x = 1'b1;
            end else begin
               r = add_sum[7:0];
               v = ~(req.acc[7] ^ req.operand[7]) & (req.acc[7] ^ add_sum[7]);
               c = add_sum[8];
            end
         end
         OP_SBC: begin
            setnz = 1'b1;
            v = (req.acc[7] ^ req.operand[7]) & (req.acc[7] ^ sub_sum[7]);
            c = ~sub_sum[8];
            if (req.decimal_in) begin
               r = bcd.sbc_result;
               x = 1'b1;
            end else begin
               r = sub_sum[7:0];
            end
         end
         OP_CMP: begin
            c = ~cmp_diff[8];
            n = cmp_diff[7];
            z = (cmp_diff[7:0] == 8'h00);
         end
         OP_BIT: begin
            z = (and_val == 8'h00);
            n = req.operand[7];
            v = req.operand[6];
         end
         OP_BITIMM: begin
            z = (and_val == 8'h00);
         end
         OP_ASL: begin
            c = req.operand[7];
            r = {req.operand[6:0], 1'b0};
            setnz = 1'b1;
         end
         OP_LSR: begin
            c = req.operand[0];
            r = {1'b0, req.operand[7:1]};
            setnz = 1'b1;
         end
         OP_ROL: begin
            c = req.operand[7];
            r = {req.operand[6:0], req.carry_in};
            setnz = 1'b1;
         end
         OP_ROR: begin
            c = req.operand[0];
            r = {req.carry_in, req.operand[7:1]};
            setnz = 1'b1;
         end
         OP_INC: begin
            r = req.operand + 8'd1;
            setnz = 1'b1;
         end
         OP_DEC: begin
            r = req.operand - 8'd1;
            setnz = 1'b1;
         end
         OP_TSB: begin
            z = (and_val == 8'h00);
            r = req.operand | req.acc;
         end
         OP_TRB: begin
            z = (and_val == 8'h00);
            r = req.operand & ~req.acc;
         end
         OP_RMB: begin
            r = req.operand & ~bit_mask;
         end
         OP_SMB: begin
            r = req.operand | bit_mask;
         end
         default: begin
            r = req.acc;
         end
      endcase
      if (setnz) begin
         n = r[7];
         z = (r == 8'h00);
      end
      rsp.result      = r;
      rsp.negative    = n;
      rsp.zero        = z;
      rsp.overflow    = v;
      rsp.carry       = c;
      rsp.extra_cycle = x;
   end

endmodule

// ===== sv/bcd_capable_8bit_alu_top.sv =====
// Top level of the BCD-capable 8-bit ALU: input register, datapath, result register.
// Depends on bcalu_pkg and bcalu_core.
//
// 6502-style ALU with decimal mode. A request is taken on any edge where
// req_valid is high and req_stall is low; the input register captures it at
// that edge, the result register once it is empty or its result is taken,
// and the result then shows on rsp_*. One request can be taken every cycle
// while rsp_stall holds no result. The datapath between the two registers is
// one 8-bit add or subtract with a decimal nibble correction. When rsp_stall
// holds a result, the input register keeps filling, so one more request is
// absorbed before req_stall rises. extra_cycle marks decimal adc and sbc for
// the sequencer; it does not slow this block.
module bcd_capable_8bit_alu_top
   import bcalu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [4:0] req_op,
   input  logic [7:0] req_acc,
   input  logic [7:0] req_operand,
   input  logic [2:0] req_bit_index,
   input  logic       req_carry_in,
   input  logic       req_decimal_in,
   input  logic       req_negative_in,
   input  logic       req_zero_in,
   input  logic       req_overflow_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result,
   output logic       rsp_negative_out,
   output logic       rsp_zero_out,
   output logic       rsp_overflow_out,
   output logic       rsp_carry_out,
   output logic       rsp_extra_cycle
);

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   req_type s1_req_in;
   logic    s2_valid_ff;
   logic    s2_valid_in;
   rsp_type s2_rsp_ff;
   rsp_type s2_rsp_in;
   logic    s2_load;
   logic    s1_load;

   // pipeline advance
   always_comb begin
      s2_load     = ~(s2_valid_ff & rsp_stall);
      s1_load     = ~s1_valid_ff | s2_load;
      req_stall   = ~s1_load;
      s1_valid_in = s1_load ? req_valid : s1_valid_ff;
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
      s1_req_in   = s1_req_ff;
      if (s1_load & req_valid) begin
         s1_req_in = '{op:          req_op,
                       acc:         req_acc,
                       operand:     req_operand,
                       bit_index:   req_bit_index,
                       carry_in:    req_carry_in,
                       decimal_in:  req_decimal_in,
                       negative_in: req_negative_in,
                       zero_in:     req_zero_in,
                       overflow_in: req_overflow_in};
      end
   end

   // datapath
   bcalu_core u_core (
      .req (s1_req_ff),
      .rsp (s2_rsp_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      if (s2_load & s1_valid_ff) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

   // result port
   assign rsp_valid        = s2_valid_ff;
   assign rsp_result       = s2_rsp_ff.result;
   assign rsp_negative_out = s2_rsp_ff.negative;
   assign rsp_zero_out     = s2_rsp_ff.zero;
   assign rsp_overflow_out = s2_rsp_ff.overflow;
   assign rsp_carry_out    = s2_rsp_ff.carry;
   assign rsp_extra_cycle  = s2_rsp_ff.extra_cycle;

`ifndef SYNTHESIS
   // an accepted request lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid & ~req_stall) |=> s1_valid_ff)
      else $error("accepted request lost");

   // a held input stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff & ~s2_load) |=> (s1_valid_ff & $stable(s1_req_ff)))
      else $error("input stage changed while blocked");

   // a moving input stage shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff & s2_load) |=> rsp_valid)
      else $error("result not produced");

   // both stages full and output blocked means no new request
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff & s2_valid_ff & rsp_stall) |-> req_stall)
      else $error("request taken with full pipeline");
`endif

endmodule

// ===== tb/bcd_capable_8bit_alu_top_test.sv =====
// Self-checking testbench for bcd_capable_8bit_alu_top: directed table, then random requests.
// Depends on bcalu_pkg and the block's RTL; each result is checked against its directed row's
// expected values if given, else a local predictor of the binary and decimal ALU behavior.
`timescale 1ns / 100ps

module bcd_capable_8bit_alu_top_test
   import bcalu_pkg::*;
();

   localparam logic [4:0] OP_UNUSED_TOP = 5'd31;
   localparam int         RANDOM_PER_PHASE = 508;
   localparam int         DRAIN_CYCLES = 10;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [4:0] req_op = '0;
   logic [7:0] req_acc = '0;
   logic [7:0] req_operand = '0;
   logic [2:0] req_bit_index = '0;
   logic       req_carry_in = 1'b0;
   logic       req_decimal_in = 1'b0;
   logic       req_negative_in = 1'b0;
   logic       req_zero_in = 1'b0;
   logic       req_overflow_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_result;
   logic       rsp_negative_out;
   logic       rsp_zero_out;
   logic       rsp_overflow_out;
   logic       rsp_carry_out;
   logic       rsp_extra_cycle;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           send_gap_pct = 0;
   int           recv_stall_pct = 0;

   bcd_capable_8bit_alu_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_acc          (req_acc),
      .req_operand      (req_operand),
      .req_bit_index    (req_bit_index),
      .req_carry_in     (req_carry_in),
      .req_decimal_in   (req_decimal_in),
      .req_negative_in  (req_negative_in),
      .req_zero_in      (req_zero_in),
      .req_overflow_in  (req_overflow_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_negative_out (rsp_negative_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_overflow_out (rsp_overflow_out),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_extra_cycle  (rsp_extra_cycle)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expected byte and flags for one request
   function automatic rsp_type alu_predict(input req_type r);
      logic [7:0]  a;
      logic [7:0]  m;
      logic [7:0]  nm;
      logic [7:0]  res;
      logic [7:0]  diff;
      logic [8:0]  sum;
      logic [5:0]  lo_sum;
      logic [9:0]  hi_sum;
      logic [15:0] bin;
      logic [15:0] lo_diff;
      logic [15:0] adj;
      logic        borrow;
      logic        set_nz;
      rsp_type     p;
      a = r.acc;
      m = r.operand;
      res = r.acc;
      set_nz = 1'b0;
      p = '{r.acc, r.negative_in, r.zero_in, r.overflow_in, r.carry_in, 1'b0};
      case (r.op)
         OP_ORA: begin
            res = a | m;
            set_nz = 1'b1;
         end
         OP_AND: begin
            res = a & m;
            set_nz = 1'b1;
         end
         OP_EOR: begin
            res = a ^ m;
            set_nz = 1'b1;
         end
         OP_ADC: begin
            p.extra_cycle = r.decimal_in;
            set_nz = 1'b1;
            if (r.decimal_in) begin
               // low digit first, its carry feeds the high digit before V is taken
               lo_sum = {2'b00, a[3:0]} + {2'b00, m[3:0]} + r.carry_in;
               hi_sum = {2'b00, a[7:4], 4'h0} + {2'b00, m[7:4], 4'h0};
               if (lo_sum > BCD_DIGIT_MAX) lo_sum = lo_sum + BCD_NIB_ADJ;
               if (lo_sum > 6'h0F) hi_sum = hi_sum + 10'h010;
               p.overflow = ~(a[7] ^ m[7]) & (a[7] ^ hi_sum[7]);
               if (hi_sum > 10'h090) hi_sum = hi_sum + BCD_HI_ADJ;
               p.carry = (hi_sum > 10'h0FF);
               res = {hi_sum[7:4], lo_sum[3:0]};
            end else begin
               sum = {1'b0, a} + {1'b0, m} + r.carry_in;
               p.overflow = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
               p.carry = sum[8];
               res = sum[7:0];
            end
         end
         OP_SBC: begin
            p.extra_cycle = r.decimal_in;
            set_nz = 1'b1;
            if (r.decimal_in) begin
               // flags come from the binary difference, digits adjusted afterwards
               borrow = ~r.carry_in;
               bin = {8'h00, a} - {8'h00, m} - borrow;
               lo_diff = {12'h000, a[3:0]} - {12'h000, m[3:0]} - borrow;
               adj = bin;
               if (bin[15]) adj = adj - BCD_HI_ADJ;
               if (lo_diff[15]) adj = adj - BCD_LO_ADJ;
               p.overflow = (a[7] ^ m[7]) & (a[7] ^ bin[7]);
               p.carry = ~bin[15];
               res = adj[7:0];
            end else begin
               nm = ~m;
               sum = {1'b0, a} + {1'b0, nm} + r.carry_in;
               p.overflow = ~(a[7] ^ nm[7]) & (a[7] ^ sum[7]);
               p.carry = sum[8];
               res = sum[7:0];
            end
         end
         OP_CMP: begin
            diff = a - m;
            p.carry = (a >= m);
            p.negative = diff[7];
            p.zero = (diff == 8'h00);
         end
         OP_BIT: begin
            p.zero = ((a & m) == 8'h00);
            p.negative = m[7];
            p.overflow = m[6];
         end
         OP_BITIMM: p.zero = ((a & m) == 8'h00);
         OP_ASL: begin
            p.carry = m[7];
            res = {m[6:0], 1'b0};
            set_nz = 1'b1;
         end
         OP_LSR: begin
            p.carry = m[0];
            res = {1'b0, m[7:1]};
            set_nz = 1'b1;
         end
         OP_ROL: begin
            p.carry = m[7];
            res = {m[6:0], r.carry_in};
            set_nz = 1'b1;
         end
         OP_ROR: begin
            p.carry = m[0];
            res = {r.carry_in, m[7:1]};
            set_nz = 1'b1;
         end
         OP_INC: begin
            res = m + 8'h01;
            set_nz = 1'b1;
         end
         OP_DEC: begin
            res = m - 8'h01;
            set_nz = 1'b1;
         end
         // zero flag taken from the bits before they change
         OP_TSB: begin
            p.zero = ((a & m) == 8'h00);
            res = m | a;
         end
         OP_TRB: begin
            p.zero = ((a & m) == 8'h00);
            res = m & ~a;
         end
         OP_RMB: res = m & ~(8'h01 << r.bit_index);
         OP_SMB: res = m | (8'h01 << r.bit_index);
         default: res = a;
      endcase
      if (set_nz) begin
         p.negative = res[7];
         p.zero = (res == 8'h00);
      end
      p.result = res;
      return p;
   endfunction

   function automatic req_type pack_request(input logic [4:0] op, input logic [7:0] acc,
                                            input logic [7:0] operand, input logic [2:0] bi,
                                            input logic c, input logic d, input logic n,
                                            input logic z, input logic v);
      req_type r;
      r = '{op, acc, operand, bi, c, d, n, z, v};
      return r;
   endfunction

   // mostly defined operations, some unused codes; decimal arithmetic often on valid digits
   function automatic req_type random_request();
      req_type r;
      r = req_type'({$urandom, $urandom});
      if ($urandom_range(99) < 5) r.op = 5'($urandom_range(31, 18));
      else r.op = 5'($urandom_range(17));
      if ((r.op == OP_ADC || r.op == OP_SBC) && $urandom_range(1)) begin
         r.decimal_in = 1'b1;
         if ($urandom_range(3) != 0) begin
            r.acc = {4'($urandom_range(9)), 4'($urandom_range(9))};
            r.operand = {4'($urandom_range(9)), 4'($urandom_range(9))};
         end
      end
      return r;
   endfunction

   // offer one request after random gaps and hold it until taken
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_acc <= r.acc;
      req_operand <= r.operand;
      req_bit_index <= r.bit_index;
      req_carry_in <= r.carry_in;
      req_decimal_in <= r.decimal_in;
      req_negative_in <= r.negative_in;
      req_zero_in <= r.zero_in;
      req_overflow_in <= r.overflow_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(typed ? want : alu_predict(r));
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // compare each taken result with the oldest expected one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result %h arrived with no request outstanding", rsp_result);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result !== want.result) begin
               $error("result: expected %h, actual %h", want.result, rsp_result);
               mismatch_count++;
            end
            if (rsp_negative_out !== want.negative) begin
               $error("negative_out: expected %b, actual %b", want.negative, rsp_negative_out);
               mismatch_count++;
            end
            if (rsp_zero_out !== want.zero) begin
               $error("zero_out: expected %b, actual %b", want.zero, rsp_zero_out);
               mismatch_count++;
            end
            if (rsp_overflow_out !== want.overflow) begin
               $error("overflow_out: expected %b, actual %b", want.overflow, rsp_overflow_out);
               mismatch_count++;
            end
            if (rsp_carry_out !== want.carry) begin
               $error("carry_out: expected %b, actual %b", want.carry, rsp_carry_out);
               mismatch_count++;
            end
            if (rsp_extra_cycle !== want.extra_cycle) begin
               $error("extra_cycle: expected %b, actual %b", want.extra_cycle, rsp_extra_cycle);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus and verdict
   initial begin
      // op, acc, operand, bit, c, d, n, z, v
      directed_rows.push_back('{pack_request(OP_ORA, 8'h00, 8'h00, 3'd0, 0, 0, 0, 0, 0),
                                1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}});
      directed_rows.push_back('{pack_request(OP_AND, 8'hFF, 8'hFF, 3'd7, 1, 0, 0, 1, 1),
                                1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}});
      directed_rows.push_back('{pack_request(OP_EOR, 8'h55, 8'hAA, 3'd2, 0, 1, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_ADC, 8'hFF, 8'h01, 3'd0, 0, 0, 0, 0, 1),
                                1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}});
      directed_rows.push_back('{pack_request(OP_ADC, 8'h7F, 8'h00, 3'd0, 1, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_ADC, 8'h99, 8'h01, 3'd0, 0, 1, 1, 0, 1),
                                1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}});
      // decimal add where V comes from the high digit before its correction
      directed_rows.push_back('{pack_request(OP_ADC, 8'h58, 8'h46, 3'd0, 1, 1, 0, 0, 0),
                                1'b0, '0});
      // invalid digits are adjusted all the same
      directed_rows.push_back('{pack_request(OP_ADC, 8'hFF, 8'hFF, 3'd0, 1, 1, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_SBC, 8'h00, 8'h01, 3'd0, 1, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_SBC, 8'h00, 8'h01, 3'd0, 1, 1, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_SBC, 8'hAA, 8'h0F, 3'd0, 0, 1, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_CMP, 8'h80, 8'h80, 3'd0, 0, 0, 1, 0, 1),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_CMP, 8'h00, 8'hFF, 3'd0, 1, 0, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_BIT, 8'h0F, 8'hF0, 3'd0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_BITIMM, 8'hFF, 8'hC0, 3'd0, 1, 0, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_ASL, 8'h00, 8'h80, 3'd0, 0, 0, 1, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_LSR, 8'hFF, 8'h01, 3'd0, 0, 0, 1, 0, 1),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_ROL, 8'h00, 8'hFF, 3'd0, 1, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_ROR, 8'h00, 8'h00, 3'd0, 1, 1, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_INC, 8'h12, 8'hFF, 3'd0, 0, 0, 1, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_DEC, 8'h34, 8'h00, 3'd0, 0, 0, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_TSB, 8'h0F, 8'hF0, 3'd0, 1, 0, 1, 0, 1),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_TRB, 8'hFF, 8'hFF, 3'd0, 0, 1, 0, 1, 0),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_RMB, 8'h00, 8'hFF, 3'd7, 1, 0, 1, 1, 1),
                                1'b0, '0});
      directed_rows.push_back('{pack_request(OP_SMB, 8'hFF, 8'h00, 3'd0, 0, 0, 0, 0, 0),
                                1'b0, '0});
      // unused code passes acc and every flag through, no extra cycle even in decimal mode
      directed_rows.push_back('{pack_request(OP_UNUSED_TOP, 8'hA5, 8'h5A, 3'd5, 1, 1, 1, 1, 1),
                                1'b1, '{8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part with the first idling mix
      send_gap_pct = 22;
      recv_stall_pct = 59;
      foreach (directed_rows[k])
         send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

      // hold off until the pipeline has drained
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);

      // random part: sender light / receiver heavy, swapped, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 22;
               recv_stall_pct = 59;
            end
            1: begin
               send_gap_pct = 59;
               recv_stall_pct = 22;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(random_request(), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("bcd_capable_8bit_alu_top test passed");
      end else begin
         $display("bcd_capable_8bit_alu_top test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("bcd_capable_8bit_alu_top test failed");
      $finish;
   end

endmodule
